// ===== src/isq_pkg.sv =====
// ----------------------------------------------------------------------------
// isq_pkg
// shared types and constants for the indexed sequence store
// ----------------------------------------------------------------------------
package isq_pkg;

    // default storage shape
    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    // fixed field widths of the channels
    localparam int OP_W    = 3;
    localparam int POS_W   = 4;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_POP_HEAD  = 3'd1,
        OP_POP_TAIL  = 3'd2,
        OP_READ      = 3'd3,
        OP_OVERWRITE = 3'd4,
        OP_DELETE    = 3'd5
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] word_in;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word_out;
        logic               ok;
        logic [COUNT_W-1:0] count_after;
    } rsp_t;

    // per-cell update control
    typedef struct packed {
        logic load;   // take the request word
        logic shift;  // take the upper neighbor's word
    } cell_ctrl_t;

endpackage

// ===== src/isq_stream_if.sv =====
// ----------------------------------------------------------------------------
// isq_stream_if
// valid/ready channel carrying one payload item per handshake
// ----------------------------------------------------------------------------
interface isq_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== src/isq_cell.sv =====
// ----------------------------------------------------------------------------
// isq_cell
// one storage cell of the row: loads a new word or takes its upper neighbor's
// ----------------------------------------------------------------------------
module isq_cell #(
    parameter int DATA_W = isq_pkg::DATA_W_DEF
) (
    input  logic                 clk,
    input  isq_pkg::cell_ctrl_t  ctrl,
    input  logic [DATA_W-1:0]    word_in,
    input  logic [DATA_W-1:0]    upper_data,
    output logic [DATA_W-1:0]    data
);
    import isq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = word_in;
        end
        else if (ctrl.shift)
        begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/indexed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store
// ordered store of up to DEPTH words with append, pop head/tail, indexed
// read, overwrite and delete
// ----------------------------------------------------------------------------
// The store holds an ordered sequence of words in a row of DEPTH cells, cell 0
// being the head. Each request on req gives exactly one item on rsp: the word
// read or popped (zero otherwise), an ok flag and the entry count after the
// request. Failures (pop when empty, append when full, position at or beyond
// the count, unused op codes) change nothing and return ok low. Removing an
// entry shifts every later cell down by one in the same cycle, so the cell
// row is updated and the result registered at the edge that accepts the
// request; a new request can be accepted each cycle the skid entry is free. A
// two-item output buffer lets the block take a request while an earlier
// result still waits on rsp. Words are stored at DATA_W bits: wider input
// bits are dropped and narrower stored words are zero-extended on output.
// Cells that were never written hold no defined value but are never read.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
    parameter int DEPTH  = isq_pkg::DEPTH_DEF,
    parameter int DATA_W = isq_pkg::DATA_W_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    isq_stream_if.sink   req,
    isq_stream_if.source rsp
);
    import isq_pkg::*;

    // count holds 0..DEPTH; compares run at the wider of count and position
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // request side
    req_t              req_item;
    logic              req_fire;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              empty;
    logic              full;
    logic              in_range;

    // decoded request
    logic              ok;
    logic              append_ok;
    logic              write_ok;
    logic              remove_ok;
    logic              tail_drop;
    logic              has_word;
    logic [CMP_W-1:0]  rd_idx;
    logic [CMP_W-1:0]  shift_from;

    // fill count
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // cell row
    logic [DATA_W-1:0] word_st;
    logic [DATA_W-1:0] cell_data [DEPTH];
    cell_ctrl_t        cell_ctrl [DEPTH];
    logic [DEPTH-1:0]  rd_hit;
    logic [DATA_W-1:0] rd_word;

    // output buffer: head register plus one skid entry
    rsp_t              rsp_new;
    rsp_t              out_reg;
    rsp_t              skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              out_fire;

    assign req_item = req.data;
    assign req_fire = req.valid && req.ready;
    assign out_fire = out_valid_reg && rsp.ready;

    // ready as long as the skid entry is free
    assign req.ready = !skid_valid_reg;

    assign pos_ext  = CMP_W'(req_item.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign in_range = (pos_ext < cnt_ext);
    assign word_st  = DATA_W'(req_item.word_in);

    // request decode
    always_comb
    begin
        ok         = 1'b0;
        append_ok  = 1'b0;
        write_ok   = 1'b0;
        remove_ok  = 1'b0;
        tail_drop  = 1'b0;
        has_word   = 1'b0;
        rd_idx     = pos_ext;
        shift_from = pos_ext;
        unique case (req_item.op)
            OP_APPEND:
            begin
                ok        = !full;
                append_ok = !full;
            end
            OP_POP_HEAD:
            begin
                ok         = !empty;
                remove_ok  = !empty;
                has_word   = 1'b1;
                rd_idx     = '0;
                shift_from = '0;
            end
            OP_POP_TAIL:
            begin
                ok        = !empty;
                tail_drop = !empty;
                has_word  = 1'b1;
                rd_idx    = cnt_ext - CMP_W'(1);
            end
            OP_READ:
            begin
                ok       = in_range;
                has_word = 1'b1;
            end
            OP_OVERWRITE:
            begin
                ok       = in_range;
                write_ok = in_range;
            end
            OP_DELETE:
            begin
                ok        = in_range;
                remove_ok = in_range;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // count after this request
    always_comb
    begin
        count_next = count_reg;
        if (append_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (remove_ok || tail_drop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (req_fire)
        begin
            count_reg <= count_next;
        end
    end

    // cell row: each cell decides load or shift from its own position
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] IDX    = CMP_W'(i);
        localparam logic [CMP_W-1:0] IDX_UP = CMP_W'(i + 1);

        assign cell_ctrl[i].load  = req_fire
                                 && ((append_ok && (IDX == cnt_ext))
                                  || (write_ok && (IDX == pos_ext)));
        // close the gap: cells from the removed one up to the last but one
        assign cell_ctrl[i].shift = req_fire && remove_ok
                                 && (IDX >= shift_from) && (IDX_UP < cnt_ext);
        assign rd_hit[i]          = (IDX == rd_idx);

        if (i == DEPTH - 1)
        begin : g_top
            isq_cell #(
                .DATA_W (DATA_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[i]),
                .word_in    (word_st),
                .upper_data (cell_data[i]),
                .data       (cell_data[i])
            );
        end
        else
        begin : g_mid
            isq_cell #(
                .DATA_W (DATA_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[i]),
                .word_in    (word_st),
                .upper_data (cell_data[i + 1]),
                .data       (cell_data[i])
            );
        end
    end

    // read port: one-hot select over the cells
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | (cell_data[i] & {DATA_W{rd_hit[i]}});
        end
    end

    always_comb
    begin
        rsp_new.word_out    = (ok && has_word) ? WORD_W'(rd_word) : '0;
        rsp_new.ok          = ok;
        rsp_new.count_after = COUNT_W'(count_next);
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= rsp_new;
            end
            else
            begin
                out_reg <= rsp_new;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // count never passes the row length
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // skid entry only holds an item behind a waiting head item
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry filled while output register empty");

    // a failed request never carries a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.ok) |-> (out_reg.word_out == '0))
        else $error("failed result with nonzero word");

    // the count moves only on an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_fire |=> (count_reg == $past(count_reg)))
        else $error("entry count changed without a request");

endmodule
